### src/mwad_pkg.sv
package mwad_pkg;

	// String capacity and the widths that follow from it.
	localparam int MAX_LEN = 4096;
	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int SYM_W = 8;
	localparam int NUM_SYM = 1 << SYM_W;
	localparam int DIST_W = SYM_W + 1;
	localparam int CNT_W = LEN_W;
	localparam int OUT_W = 13;
	localparam int OUT_MAX = (1 << OUT_W) - 1;

	// Job queue between the loader and the scan engine.
	localparam int JQ_DEPTH = 2;
	localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

	// One finished string, handed from the loader to the scan engine.
	typedef struct packed {
		logic bank;
		logic [LEN_W-1:0] len;
		logic [DIST_W-1:0] n_kinds;
		logic ovf;
	} job_t;

	// Write into the symbol store.
	typedef struct packed {
		logic en;
		logic bank;
		logic [ADDR_W-1:0] addr;
		logic [SYM_W-1:0] data;
	} store_wr_t;

	// Release of a store bank once its scan is finished.
	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

	// Status of the scan engine.
	typedef struct packed {
		logic busy;
		logic bank;
	} back_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD_R,
		BK_CNT_R,
		BK_UPD_R,
		BK_RD_L,
		BK_CNT_L,
		BK_UPD_L,
		BK_DONE
	} back_state_t;

	// Clamp a window length to the width of the result field.
	function automatic logic [OUT_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		if (32'(len) > OUT_MAX) begin
			return OUT_W'(OUT_MAX);
		end
		return OUT_W'(len);
	endfunction

endpackage

### src/mwad_ram.sv
module mwad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/mwad_front.sv
module mwad_front import mwad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sym_valid,
	output logic             sym_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	input  rel_t             rel,
	output store_wr_t        store_wr,
	output logic             job_push,
	output job_t             job_in
);

	logic               bank_q;
	logic [1:0]         busy_q;
	logic [LEN_W-1:0]   len_q;
	logic [DIST_W-1:0]  dist_q;
	logic               ovf_q;
	logic [NUM_SYM-1:0] seen_q;

	logic              accept;
	logic              full;
	logic              new_kind;
	logic [LEN_W-1:0]  len_nx;
	logic [DIST_W-1:0] dist_nx;
	logic              ovf_nx;
	logic [1:0]        busy_nx;

	// A request is taken only while the current bank holds no string in work.
	assign sym_ready = !busy_q[bank_q];
	assign accept = sym_valid && sym_ready;
	assign full = (len_q == LEN_W'(MAX_LEN));
	assign new_kind = !full && !seen_q[symbol];

	assign len_nx = full ? len_q : len_q + LEN_W'(1);
	assign dist_nx = dist_q + DIST_W'(new_kind);
	assign ovf_nx = ovf_q || full;

	// Store the symbol unless the bank is already full.
	assign store_wr.en = accept && !full;
	assign store_wr.bank = bank_q;
	assign store_wr.addr = len_q[ADDR_W-1:0];
	assign store_wr.data = symbol;

	// The last symbol closes the string and hands it over as a job.
	assign job_push = accept && last;
	assign job_in.bank = bank_q;
	assign job_in.len = len_nx;
	assign job_in.n_kinds = dist_nx;
	assign job_in.ovf = ovf_nx;

	// Bank ownership: released by the scan engine, claimed by a closed string.
	always_comb begin
		busy_nx = busy_q;
		if (rel.en) begin
			busy_nx[rel.bank] = 1'b0;
		end
		if (accept && last) begin
			busy_nx[bank_q] = 1'b1;
		end
	end

	// Per-string bookkeeping and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			busy_q <= '0;
			len_q <= '0;
			dist_q <= '0;
			ovf_q <= 1'b0;
			seen_q <= '0;
		end else begin
			busy_q <= busy_nx;
			if (accept) begin
				if (last) begin
					bank_q <= !bank_q;
					len_q <= '0;
					dist_q <= '0;
					ovf_q <= 1'b0;
					seen_q <= '0;
				end else begin
					len_q <= len_nx;
					dist_q <= dist_nx;
					ovf_q <= ovf_nx;
					if (new_kind) begin
						seen_q[symbol] <= 1'b1;
					end
				end
			end
		end
	end

endmodule

### src/mwad_job_fifo.sv
module mwad_job_fifo import mwad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic not_empty,
	output logic full,
	output job_t head
);

	job_t                entry_q [JQ_DEPTH];
	logic [JQ_PTR_W-1:0] wp_q;
	logic [JQ_PTR_W-1:0] rp_q;
	logic [JQ_CNT_W-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full = (cnt_q == JQ_CNT_W'(JQ_DEPTH));
	assign head = entry_q[rp_q];

	// Entry storage; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + JQ_PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + JQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + JQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - JQ_CNT_W'(1);
			end
		end
	end

endmodule

### src/mwad_back.sv
module mwad_back import mwad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              job_pop,
	output logic [ADDR_W-1:0] store_raddr,
	input  logic [SYM_W-1:0]  store_rdata,
	output rel_t              rel,
	output back_stat_t        stat,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [OUT_W-1:0]  min_window,
	output logic              truncated
);

	back_state_t state_q;
	back_state_t state_nx;

	job_t               job_q;
	logic [LEN_W-1:0]   right_q;
	logic [LEN_W-1:0]   left_q;
	logic [LEN_W-1:0]   best_q;
	logic [DIST_W-1:0]  kinds_q;
	logic [SYM_W-1:0]   sym_q;
	logic               cnt_vld_q;
	logic [NUM_SYM-1:0] cvld_q;
	logic               res_valid_q;
	logic [OUT_W-1:0]   min_window_q;
	logic               truncated_q;

	logic               cnt_we;
	logic [CNT_W-1:0]   cnt_wdata;
	logic [CNT_W-1:0]   cnt_rdata;
	logic [CNT_W-1:0]   cnt_now;
	logic [DIST_W-1:0]  kinds_inc;
	logic [DIST_W-1:0]  kinds_dec;
	logic [LEN_W-1:0]   right_nx;
	logic [LEN_W-1:0]   win_len;
	logic               out_load;

	// Window counts; an entry whose valid bit is clear reads as zero.
	mwad_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_SYM)
	) u_counts (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(sym_q),
		.wdata(cnt_wdata),
		.raddr(store_rdata),
		.rdata(cnt_rdata)
	);

	// Shared arithmetic of the window update.
	assign cnt_now = cnt_vld_q ? cnt_rdata : '0;
	assign kinds_inc = kinds_q + DIST_W'(cnt_now == '0);
	assign kinds_dec = kinds_q - DIST_W'(cnt_now == CNT_W'(1));
	assign right_nx = right_q + LEN_W'(1);
	assign win_len = right_q - left_q + LEN_W'(1);
	assign out_load = (state_q == BK_DONE) && (!res_valid_q || res_ready);

	// Next state of the scan sequencer.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					state_nx = BK_RD_R;
				end
			end
			BK_RD_R:  state_nx = BK_CNT_R;
			BK_CNT_R: state_nx = BK_UPD_R;
			BK_UPD_R: begin
				if (kinds_inc == job_q.n_kinds) begin
					state_nx = BK_RD_L;
				end else if (right_nx == job_q.len) begin
					state_nx = BK_DONE;
				end else begin
					state_nx = BK_RD_R;
				end
			end
			BK_RD_L:  state_nx = BK_CNT_L;
			BK_CNT_L: state_nx = BK_UPD_L;
			BK_UPD_L: begin
				if (kinds_dec == job_q.n_kinds) begin
					state_nx = BK_RD_L;
				end else if (right_nx == job_q.len) begin
					state_nx = BK_DONE;
				end else begin
					state_nx = BK_RD_R;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// Memory controls and handshakes of the sequencer.
	always_comb begin
		job_pop = 1'b0;
		store_raddr = right_q[ADDR_W-1:0];
		cnt_we = 1'b0;
		cnt_wdata = cnt_now + CNT_W'(1);
		rel.en = 1'b0;
		rel.bank = job_q.bank;
		case (state_q)
			BK_IDLE:  job_pop = job_valid;
			BK_RD_L:  store_raddr = left_q[ADDR_W-1:0];
			BK_UPD_R: cnt_we = 1'b1;
			BK_UPD_L: begin
				cnt_we = 1'b1;
				cnt_wdata = cnt_now - CNT_W'(1);
			end
			BK_DONE:  rel.en = out_load;
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != BK_IDLE);
	assign stat.bank = job_q.bank;

	// Sequencer state and valid bits of the count memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cvld_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (job_pop) begin
				cvld_q <= '0;
			end else if (state_q == BK_UPD_R) begin
				cvld_q[sym_q] <= 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Window pointers, kind count and best length.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					right_q <= '0;
					left_q <= '0;
					kinds_q <= '0;
					best_q <= job.len;
				end
			end
			BK_CNT_R, BK_CNT_L: begin
				sym_q <= store_rdata;
				cnt_vld_q <= cvld_q[store_rdata];
			end
			BK_UPD_R: begin
				kinds_q <= kinds_inc;
				if (kinds_inc != job_q.n_kinds) begin
					right_q <= right_nx;
				end
			end
			BK_UPD_L: begin
				kinds_q <= kinds_dec;
				left_q <= left_q + LEN_W'(1);
				if (win_len < best_q) begin
					best_q <= win_len;
				end
				if (kinds_dec != job_q.n_kinds) begin
					right_q <= right_nx;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			min_window_q <= sat_len(best_q);
			truncated_q <= job_q.ovf;
		end
	end

	assign res_valid = res_valid_q;
	assign min_window = min_window_q;
	assign truncated = truncated_q;

endmodule

### src/min_window_all_distinct_unit.sv
// Shortest window holding every distinct symbol of a string.
//
// Input channel (sym_valid/sym_ready): one 8-bit symbol per request, with
// last set on the final symbol of a string. Loading takes one symbol per
// cycle while sym_ready is high. Symbols past the 4096-entry capacity
// are dropped and reported. Output channel (res_valid/res_ready): one
// result per string, giving the window length and the truncated flag.
// The store has two banks, so the next string loads while the previous one
// is scanned; loading stalls only when both banks hold strings in work.
// The scan engine walks both window edges over the stored string, and each
// edge step is a store read, a count read and a count write.
// The result sits in an output register; while the receiver stalls, the
// engine holds finished work and loading continues into the free bank.
// Reset clears all control state; no memory clearing pass is needed.
module min_window_all_distinct_unit import mwad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sym_valid,
	output logic             sym_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [OUT_W-1:0] min_window,
	output logic             truncated
);

	store_wr_t         store_wr;
	rel_t              rel;
	back_stat_t        stat;
	logic              job_push;
	job_t              job_in;
	logic              job_pop;
	logic              job_valid;
	logic              job_full;
	job_t              job_head;
	logic [ADDR_W-1:0] store_raddr;
	logic [SYM_W-1:0]  rdata0;
	logic [SYM_W-1:0]  rdata1;
	logic [SYM_W-1:0]  store_rdata;

	// Loader: stores symbols and tracks the distinct kinds of each string.
	mwad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.symbol   (symbol),
		.last     (last),
		.rel      (rel),
		.store_wr (store_wr),
		.job_push (job_push),
		.job_in   (job_in)
	);

	// Queue of finished strings waiting for the scan.
	mwad_job_fifo u_jobs (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job_in),
		.pop      (job_pop),
		.not_empty(job_valid),
		.full     (job_full),
		.head     (job_head)
	);

	// Two banks of the symbol store.
	mwad_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_LEN)
	) u_store0 (
		.clk  (clk),
		.we   (store_wr.en && !store_wr.bank),
		.waddr(store_wr.addr),
		.wdata(store_wr.data),
		.raddr(store_raddr),
		.rdata(rdata0)
	);

	mwad_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_LEN)
	) u_store1 (
		.clk  (clk),
		.we   (store_wr.en && store_wr.bank),
		.waddr(store_wr.addr),
		.wdata(store_wr.data),
		.raddr(store_raddr),
		.rdata(rdata1)
	);

	assign store_rdata = stat.bank ? rdata1 : rdata0;

	// Scan engine: sliding window over the stored string.
	mwad_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job_head),
		.job_pop    (job_pop),
		.store_raddr(store_raddr),
		.store_rdata(store_rdata),
		.rel        (rel),
		.stat       (stat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.min_window (min_window),
		.truncated  (truncated)
	);

	// The job queue never receives more strings than there are banks.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into a full queue");

	// The loader never writes into the bank under scan.
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(store_wr.en && stat.busy) |-> (store_wr.bank != stat.bank))
		else $error("store write hit the bank being scanned");

	// A window always holds at least one symbol.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (min_window != '0))
		else $error("zero window length reported");

endmodule
